// ===== sv/bdq_pkg.sv =====
// Shared constants and types for the bounded deque.
package bdq_pkg;

	localparam int DEPTH  = 16;
	localparam int ELEM_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [STAT_W-1:0] stat_t;

	localparam kind_t K_PUSH_F   = 3'd0;
	localparam kind_t K_PUSH_B   = 3'd1;
	localparam kind_t K_POP_F    = 3'd2;
	localparam kind_t K_POP_B    = 3'd3;
	localparam kind_t K_PEEK_F   = 3'd4;
	localparam kind_t K_PEEK_B   = 3'd5;
	localparam kind_t K_CONTAINS = 3'd6;
	localparam kind_t K_UNUSED   = 3'd7;

	localparam stat_t ST_OK    = 2'd0;
	localparam stat_t ST_EMPTY = 2'd1;
	localparam stat_t ST_FULL  = 2'd2;

endpackage

// ===== sv/bdq_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
module bdq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/bounded_deque_unit.sv =====
// Bounded deque top level: request sequencer, slot adder and entry store.
//
// Requests enter on start while busy is low; each gives one result, shown for one
// cycle with done high, which the receiver must take then. A push or an unused
// request finishes in the execute state; a pop or peek first reads its entry from
// the entry store (with no read when the deque is empty), and a contains walks the
// entries one per cycle from the front, stopping at the first match or at the last
// entry, so it compares at most the entry count, and so at most DEPTH. Every entry
// read goes through the single read port of the entry store. All slot positions
// come from one shared add-and-wrap unit on the front index.
module bounded_deque_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  bdq_pkg::kind_t        kind,
	input  bdq_pkg::elem_t        value,
	output logic                  busy,
	output logic                  done,
	output bdq_pkg::elem_t        value_out,
	output bdq_pkg::stat_t        status,
	output logic                  found,
	output bdq_pkg::cnt_t         count_out
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_WALK = 2'd3;

	localparam int SUM_W = bdq_pkg::IDX_W + 1;

	logic [1:0]      state_q;
	bdq_pkg::kind_t  kind_q;
	bdq_pkg::elem_t  value_q;
	bdq_pkg::idx_t   front_q;
	bdq_pkg::cnt_t   count_q;
	bdq_pkg::idx_t   walk_q;
	logic            done_q;
	bdq_pkg::elem_t  value_out_q;
	bdq_pkg::stat_t  status_q;
	logic            found_q;

	bdq_pkg::idx_t   off;
	logic [SUM_W-1:0] sum;
	bdq_pkg::idx_t   slot;
	bdq_pkg::elem_t  rdata;
	logic            full;
	logic            empty;
	logic            is_push;
	logic            ram_we;
	logic            walk_last;

	assign full    = (count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
	assign empty   = (count_q == '0);
	assign is_push = (kind_q == bdq_pkg::K_PUSH_F) || (kind_q == bdq_pkg::K_PUSH_B);
	assign ram_we  = (state_q == S_EXEC) && is_push && !full;
	assign walk_last = ((bdq_pkg::CNT_W'(walk_q) + 1'b1) == count_q);

	// offset from the front for the shared slot adder
	always_comb begin
		off = '0;
		case (state_q)
			S_EXEC: begin
				case (kind_q) inside
					bdq_pkg::K_PUSH_F:                   off = bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1);
					bdq_pkg::K_PUSH_B:                   off = count_q[bdq_pkg::IDX_W-1:0];
					bdq_pkg::K_POP_B, bdq_pkg::K_PEEK_B: off = bdq_pkg::IDX_W'(count_q - 1'b1);
					default:                             off = '0;
				endcase
			end
			S_READ:  off = bdq_pkg::IDX_W'(1);
			S_WALK:  off = walk_q + 1'b1;
			default: off = '0;
		endcase
	end

	// both operands stay below DEPTH, so one conditional subtract wraps
	assign sum  = {1'b0, front_q} + {1'b0, off};
	assign slot = (sum >= SUM_W'(bdq_pkg::DEPTH)) ?
		bdq_pkg::IDX_W'(sum - SUM_W'(bdq_pkg::DEPTH)) : sum[bdq_pkg::IDX_W-1:0];

	bdq_ram #(
		.DEPTH (bdq_pkg::DEPTH),
		.WIDTH (bdq_pkg::ELEM_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (value_q),
		.raddr (slot),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (kind_q) inside
						bdq_pkg::K_PUSH_F, bdq_pkg::K_PUSH_B: begin
							if (!full) begin
								count_q <= count_q + 1'b1;
								if (kind_q == bdq_pkg::K_PUSH_F) begin
									front_q <= slot;
								end
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						bdq_pkg::K_POP_F, bdq_pkg::K_POP_B,
						bdq_pkg::K_PEEK_F, bdq_pkg::K_PEEK_B: begin
							if (empty) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_READ;
							end
						end
						bdq_pkg::K_CONTAINS: begin
							if (empty) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_WALK;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_READ: begin
					if (kind_q == bdq_pkg::K_POP_F) begin
						front_q <= slot;
						count_q <= count_q - 1'b1;
					end else if (kind_q == bdq_pkg::K_POP_B) begin
						count_q <= count_q - 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if ((rdata == value_q) || walk_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item capture, walk position and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q  <= kind;
					value_q <= value;
				end
			end
			S_EXEC: begin
				walk_q      <= '0;
				value_out_q <= '0;
				found_q     <= 1'b0;
				status_q    <= bdq_pkg::ST_OK;
				if (is_push && full) begin
					status_q <= bdq_pkg::ST_FULL;
				end else if (!is_push && kind_q != bdq_pkg::K_CONTAINS &&
				             kind_q != bdq_pkg::K_UNUSED && empty) begin
					status_q <= bdq_pkg::ST_EMPTY;
				end
			end
			S_READ: begin
				value_out_q <= rdata;
			end
			S_WALK: begin
				walk_q <= walk_q + 1'b1;
				if (rdata == value_q) begin
					found_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign found     = found_q;
	assign count_out = count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
		else $error("entry count above depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bdq_pkg::ST_FULL) |->
		(count_out == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)))
		else $error("full status with room left");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bdq_pkg::ST_EMPTY) |-> (count_out == '0 && value_out == '0))
		else $error("empty status with entries held");

	a_found_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> $past(state_q == S_WALK))
		else $error("found set outside a contains walk");
`endif

endmodule
